// ===== hdl/cpbc_pkg.sv =====
// Package: widths, reset values, register indexes and sequencer states of the balance controller.
package cpbc_pkg;

    localparam int GAIN_W  = 31;
    localparam int DATA_W  = 32;
    localparam int IDX_W   = 3;
    localparam int FORCE_W = 21;
    localparam int MUL_A_W = 34;
    localparam int MUL_B_W = 33;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int INT_W   = 34;
    localparam int ACC_W   = 52;
    localparam int TGT_W   = 33;
    localparam int DIFF_W  = 34;

    localparam logic [GAIN_W-1:0] RST_ANGLE_PROP = 31'd1310720;
    localparam logic [GAIN_W-1:0] RST_ANGLE_DERIV = 31'd983040;
    localparam logic [GAIN_W-1:0] RST_POS_PROP  = 31'd6554;
    localparam logic [GAIN_W-1:0] RST_POS_INTEG = 31'd0;
    localparam logic [GAIN_W-1:0] RST_POS_DERIV = 31'd49152;
    localparam logic [GAIN_W-1:0] RST_LEAN_LIM  = 31'd3277;
    localparam logic [GAIN_W-1:0] RST_INTEG_LIM = 31'd65536;
    localparam logic [DATA_W-1:0] RST_TICK      = 32'd4294967;

    localparam logic signed [ACC_W-1:0] PI_Q16    = 52'sd205887;
    localparam logic signed [ACC_W-1:0] FORCE_LIM = 52'sd655360;

    localparam logic [IDX_W-1:0] REG_ANGLE_PROP  = 3'd0;
    localparam logic [IDX_W-1:0] REG_ANGLE_DERIV = 3'd1;
    localparam logic [IDX_W-1:0] REG_POS_PROP    = 3'd2;
    localparam logic [IDX_W-1:0] REG_POS_INTEG   = 3'd3;
    localparam logic [IDX_W-1:0] REG_POS_DERIV   = 3'd4;
    localparam logic [IDX_W-1:0] REG_LEAN_LIM    = 3'd5;
    localparam logic [IDX_W-1:0] REG_INTEG_LIM   = 3'd6;
    localparam logic [IDX_W-1:0] REG_TICK        = 3'd7;

    typedef enum logic [10:0] {
        ST_IDLE = 11'b000_0000_0001,
        ST_INT  = 11'b000_0000_0010,
        ST_PX   = 11'b000_0000_0100,
        ST_DV   = 11'b000_0000_1000,
        ST_KI   = 11'b000_0001_0000,
        ST_TSUM = 11'b000_0010_0000,
        ST_TCLP = 11'b000_0100_0000,
        ST_DIFF = 11'b000_1000_0000,
        ST_KP   = 11'b001_0000_0000,
        ST_FSUM = 11'b010_0000_0000,
        ST_OUT  = 11'b100_0000_0000
    } state_t;

endpackage

// ===== hdl/cascaded_pid_balance_controller_unit.sv =====
// Cascaded PID balance controller: sequencer around one shared multiplier.
// An input word is accepted in the idle state; the sequencer then steps through INT, PX, DV,
// KI, TSUM, TCLP, DIFF, KP, FSUM and OUT, and posts the result word from OUT once the output
// is free. The single shared multiplier is used for six products in turn. s_tready is high only in the idle state.
// Reset (aresetn, synchronous, active low): gains and limits to defaults,
// position integral to zero, sequencer idle, output word empty.
module cascaded_pid_balance_controller_unit (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // [31:0] cart_position, [63:32] cart_velocity, [95:64] pole_angle, [127:96] pole_rate
    input  logic [127:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // [20:0] drive_force, [23:21] zero
    output logic [23:0]  m_tdata,
    // [0] force_clipped, [1] lean_clipped, [2] integral_clipped
    output logic [2:0]   m_tuser,
    input  logic         cfg_wr_en,
    input  logic [2:0]   cfg_wr_index,
    input  logic [31:0]  cfg_wr_data
);

    cpbc_pkg::state_t state_reg, state_next;

    logic [cpbc_pkg::GAIN_W-1:0] kp_th_reg, kd_th_reg, kp_x_reg, ki_x_reg, kd_x_reg;
    logic [cpbc_pkg::GAIN_W-1:0] lean_lim_reg, int_lim_reg;
    logic [cpbc_pkg::DATA_W-1:0] tick_reg;

    logic signed [cpbc_pkg::DATA_W-1:0]  x_reg, v_reg, th_reg, w_reg;
    logic signed [cpbc_pkg::DATA_W-1:0]  integ_reg, integ_next;
    logic signed [cpbc_pkg::PROD_W-1:0]  prod_reg, prod_next;
    logic signed [cpbc_pkg::ACC_W-1:0]   acc_reg, acc_next;
    logic signed [cpbc_pkg::TGT_W-1:0]   tgt_reg, tgt_next;
    logic signed [cpbc_pkg::DIFF_W-1:0]  diff_reg;
    logic                                int_hit_reg, int_hit_next;
    logic                                lean_hit_reg, lean_hit_next;

    logic                                m_valid_reg;
    logic [cpbc_pkg::FORCE_W-1:0]        force_reg, force_next;
    logic [2:0]                          flags_reg, flags_next;

    logic signed [cpbc_pkg::MUL_A_W-1:0] mul_a;
    logic signed [cpbc_pkg::MUL_B_W-1:0] mul_b;
    logic signed [cpbc_pkg::ACC_W-1:0]   prod_q16;
    logic signed [cpbc_pkg::INT_W-1:0]   int_sum, int_lim_s, int_lim_neg;
    logic signed [cpbc_pkg::ACC_W-1:0]   tgt_lo, tgt_hi, force_lo;
    logic                                out_free;

    assign s_tready = (state_reg == cpbc_pkg::ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, force_reg};
    assign m_tuser  = flags_reg;
    assign out_free = !m_valid_reg || m_tready;

    assign prod_q16    = {prod_reg[cpbc_pkg::PROD_W-1], prod_reg[cpbc_pkg::PROD_W-1:16]};
    assign int_sum     = {{2{integ_reg[31]}}, integ_reg} + prod_reg[65:32];
    assign int_lim_s   = {3'b000, int_lim_reg};
    assign int_lim_neg = -int_lim_s;
    assign tgt_lo      = cpbc_pkg::PI_Q16 - {21'd0, lean_lim_reg};
    assign tgt_hi      = cpbc_pkg::PI_Q16 + {21'd0, lean_lim_reg};
    assign force_lo    = -cpbc_pkg::FORCE_LIM;

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            cpbc_pkg::ST_INT: begin
                mul_a = -{{2{x_reg[31]}}, x_reg};
                mul_b = {1'b0, tick_reg};
            end
            cpbc_pkg::ST_PX: begin
                mul_a = {{2{x_reg[31]}}, x_reg};
                mul_b = {2'b00, kp_x_reg};
            end
            cpbc_pkg::ST_DV: begin
                mul_a = {{2{v_reg[31]}}, v_reg};
                mul_b = {2'b00, kd_x_reg};
            end
            cpbc_pkg::ST_KI: begin
                mul_a = {{2{integ_reg[31]}}, integ_reg};
                mul_b = {2'b00, ki_x_reg};
            end
            cpbc_pkg::ST_TSUM: begin
                mul_a = {{2{w_reg[31]}}, w_reg};
                mul_b = {2'b00, kd_th_reg};
            end
            cpbc_pkg::ST_KP: begin
                mul_a = diff_reg;
                mul_b = {2'b00, kp_th_reg};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        state_next    = state_reg;
        prod_next     = prod_reg;
        acc_next      = acc_reg;
        integ_next    = integ_reg;
        tgt_next      = tgt_reg;
        int_hit_next  = int_hit_reg;
        lean_hit_next = lean_hit_reg;
        force_next    = force_reg;
        flags_next    = flags_reg;
        case (state_reg)
            cpbc_pkg::ST_IDLE: begin
                if (s_tvalid) state_next = cpbc_pkg::ST_INT;
            end
            cpbc_pkg::ST_INT: begin
                prod_next  = mul_a * mul_b;
                state_next = cpbc_pkg::ST_PX;
            end
            cpbc_pkg::ST_PX: begin
                if (int_sum > int_lim_s) begin
                    integ_next   = int_lim_s[31:0];
                    int_hit_next = 1'b1;
                end else if (int_sum < int_lim_neg) begin
                    integ_next   = int_lim_neg[31:0];
                    int_hit_next = 1'b1;
                end else begin
                    integ_next   = int_sum[31:0];
                    int_hit_next = 1'b0;
                end
                prod_next  = mul_a * mul_b;
                state_next = cpbc_pkg::ST_DV;
            end
            cpbc_pkg::ST_DV: begin
                acc_next   = cpbc_pkg::PI_Q16 + prod_q16;
                prod_next  = mul_a * mul_b;
                state_next = cpbc_pkg::ST_KI;
            end
            cpbc_pkg::ST_KI: begin
                acc_next   = acc_reg + prod_q16;
                prod_next  = mul_a * mul_b;
                state_next = cpbc_pkg::ST_TSUM;
            end
            cpbc_pkg::ST_TSUM: begin
                acc_next   = acc_reg - prod_q16;
                prod_next  = mul_a * mul_b;
                state_next = cpbc_pkg::ST_TCLP;
            end
            cpbc_pkg::ST_TCLP: begin
                if (acc_reg > tgt_hi) begin
                    tgt_next      = tgt_hi[cpbc_pkg::TGT_W-1:0];
                    lean_hit_next = 1'b1;
                end else if (acc_reg < tgt_lo) begin
                    tgt_next      = tgt_lo[cpbc_pkg::TGT_W-1:0];
                    lean_hit_next = 1'b1;
                end else begin
                    tgt_next      = acc_reg[cpbc_pkg::TGT_W-1:0];
                    lean_hit_next = 1'b0;
                end
                state_next = cpbc_pkg::ST_DIFF;
            end
            cpbc_pkg::ST_DIFF: begin
                acc_next   = -prod_q16;
                state_next = cpbc_pkg::ST_KP;
            end
            cpbc_pkg::ST_KP: begin
                prod_next  = mul_a * mul_b;
                state_next = cpbc_pkg::ST_FSUM;
            end
            cpbc_pkg::ST_FSUM: begin
                acc_next   = acc_reg + prod_q16;
                state_next = cpbc_pkg::ST_OUT;
            end
            cpbc_pkg::ST_OUT: begin
                if (out_free) begin
                    if (acc_reg > cpbc_pkg::FORCE_LIM) begin
                        force_next = cpbc_pkg::FORCE_LIM[cpbc_pkg::FORCE_W-1:0];
                        flags_next = {int_hit_reg, lean_hit_reg, 1'b1};
                    end else if (acc_reg < force_lo) begin
                        force_next = force_lo[cpbc_pkg::FORCE_W-1:0];
                        flags_next = {int_hit_reg, lean_hit_reg, 1'b1};
                    end else begin
                        force_next = acc_reg[cpbc_pkg::FORCE_W-1:0];
                        flags_next = {int_hit_reg, lean_hit_reg, 1'b0};
                    end
                    state_next = cpbc_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = cpbc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= cpbc_pkg::ST_IDLE;
            m_valid_reg  <= 1'b0;
            integ_reg    <= '0;
            kp_th_reg    <= cpbc_pkg::RST_ANGLE_PROP;
            kd_th_reg    <= cpbc_pkg::RST_ANGLE_DERIV;
            kp_x_reg     <= cpbc_pkg::RST_POS_PROP;
            ki_x_reg     <= cpbc_pkg::RST_POS_INTEG;
            kd_x_reg     <= cpbc_pkg::RST_POS_DERIV;
            lean_lim_reg <= cpbc_pkg::RST_LEAN_LIM;
            int_lim_reg  <= cpbc_pkg::RST_INTEG_LIM;
            tick_reg     <= cpbc_pkg::RST_TICK;
        end else begin
            state_reg <= state_next;
            integ_reg <= integ_next;
            if (state_reg == cpbc_pkg::ST_OUT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_wr_en) begin
                case (cfg_wr_index)
                    cpbc_pkg::REG_ANGLE_PROP:  kp_th_reg    <= cfg_wr_data[30:0];
                    cpbc_pkg::REG_ANGLE_DERIV: kd_th_reg    <= cfg_wr_data[30:0];
                    cpbc_pkg::REG_POS_PROP:    kp_x_reg     <= cfg_wr_data[30:0];
                    cpbc_pkg::REG_POS_INTEG:   ki_x_reg     <= cfg_wr_data[30:0];
                    cpbc_pkg::REG_POS_DERIV:   kd_x_reg     <= cfg_wr_data[30:0];
                    cpbc_pkg::REG_LEAN_LIM:    lean_lim_reg <= cfg_wr_data[30:0];
                    cpbc_pkg::REG_INTEG_LIM:   int_lim_reg  <= cfg_wr_data[30:0];
                    cpbc_pkg::REG_TICK:        tick_reg     <= cfg_wr_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            x_reg  <= s_tdata[31:0];
            v_reg  <= s_tdata[63:32];
            th_reg <= s_tdata[95:64];
            w_reg  <= s_tdata[127:96];
        end
        if (state_reg == cpbc_pkg::ST_DIFF) begin
            diff_reg <= {tgt_reg[cpbc_pkg::TGT_W-1], tgt_reg} - {{2{th_reg[31]}}, th_reg};
        end
        prod_reg     <= prod_next;
        acc_reg      <= acc_next;
        tgt_reg      <= tgt_next;
        int_hit_reg  <= int_hit_next;
        lean_hit_reg <= lean_hit_next;
        force_reg    <= force_next;
        flags_reg    <= flags_next;
    end

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("accepted a word while busy");

    a_force_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(m_tdata[20:0]) <= 21'sd655360
                      && $signed(m_tdata[20:0]) >= -21'sd655360))
        else $error("drive force beyond limit");

    a_force_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> (m_tdata[20:0] == 21'd655360
                                    || m_tdata[20:0] == 21'h160000))
        else $error("force flag without force at limit");

    a_result_then_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == cpbc_pkg::ST_OUT && out_free |=> m_tvalid && s_tready)
        else $error("result not posted on completion");

endmodule
